@@ hdl/dq_pkg.sv @@
`default_nettype none
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST_FWD   = 3'd4,
    ACT_LIST_BWD   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_POPPED = 3'd1,
    ST_LISTED = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] result_value;
    logic               last;
  } out_item_t;

  // Classified command passed from the front part to the back part
  typedef struct packed {
    action_e op;
    data_t   value;
  } cmd_t;

  // Keep the low DATA_WIDTH bits of the sign-extended input
  function automatic data_t to_stored(logic signed [31:0] v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored entry and cut it to 32 bits
  function automatic logic signed [31:0] to_result(data_t v);
    logic signed [63:0] wide;
    wide = 64'($signed(v));
    return wide[31:0];
  endfunction

  // Ring position a + b, b at most DEPTH
  function automatic idx_t wrap_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t dec_idx(idx_t a);
    return (a == '0) ? IDX_W'(DEPTH - 1) : a - 1'b1;
  endfunction

  function automatic idx_t step_idx(idx_t a, logic backward);
    return backward ? dec_idx(a) : wrap_add(a, CNT_W'(1));
  endfunction

endpackage
`default_nettype wire

@@ hdl/double_ended_queue.sv @@
`default_nettype none
// Bounded double-ended queue of dq_pkg::DEPTH signed entries in a ring buffer.
// An item is taken when start is high and busy is low; busy rises only while
// the two-entry command queue between the front and back parts is full.
// Results appear on result for one cycle each, marked by strobe, and cannot be
// held off. A push, a full push or an empty pop/listing is handled in the back
// part's idle state alone; a pop also passes through S_POP, as the entry comes
// through the registered RAM read port; a listing of n entries gives one result
// per cycle, the final one marked last. Unused action codes are dropped
// without a result. The entry RAM is not cleared; only entries inside the
// count are read.
module double_ended_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire dq_pkg::in_item_t item,
  output logic                  busy,
  output logic                  strobe,
  output dq_pkg::out_item_t     result
);

  logic         cmd_valid;
  logic         cmd_take;
  dq_pkg::cmd_t cmd;

  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  dq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
`default_nettype wire

@@ hdl/dq_ram.sv @@
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/dq_front.sv @@
`default_nettype none
module dq_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire dq_pkg::in_item_t item,
  output logic                  busy,
  output logic                  cmd_valid,
  output dq_pkg::cmd_t          cmd,
  input  wire logic             cmd_take
);

  dq_pkg::cmd_t q [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         keep;
  logic         push;

  // Classify: drop unused action codes here
  always_comb begin
    unique case (item.action) inside
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_POP_FRONT,
      dq_pkg::ACT_POP_BACK, dq_pkg::ACT_LIST_FWD, dq_pkg::ACT_LIST_BWD: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy && keep;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  // Hold the classified item in the queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].op    <= dq_pkg::action_e'(item.action);
      q[wr_ptr].value <= dq_pkg::to_stored(item.item_value);
    end
  end

  // Advance the queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_take);
    end
  end

endmodule
`default_nettype wire

@@ hdl/dq_back.sv @@
`default_nettype none
module dq_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  wire dq_pkg::cmd_t cmd,
  output logic              cmd_take,
  output logic              strobe,
  output dq_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t            state, state_next;
  dq_pkg::idx_t      front, front_next;
  dq_pkg::cnt_t      count, count_next;
  dq_pkg::idx_t      ptr, ptr_next;
  dq_pkg::cnt_t      rem, rem_next;
  logic              dir, dir_next;
  logic              strobe_next;
  dq_pkg::out_item_t result_next;
  dq_pkg::idx_t      start_pos;

  logic              we;
  dq_pkg::idx_t      waddr;
  dq_pkg::idx_t      raddr;
  dq_pkg::data_t     rdata;

  dq_ram #(
    .WIDTH (dq_pkg::DATA_WIDTH),
    .DEPTH (dq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd_take = (state == S_IDLE) && cmd_valid;

  // Carry out one command, or advance a listing by one entry
  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    ptr_next    = ptr;
    rem_next    = rem;
    dir_next    = dir;
    strobe_next = 1'b0;
    result_next = '{status: dq_pkg::ST_EMPTY, result_value: '0, last: 1'b1};
    we          = 1'b0;
    waddr       = front;
    raddr       = ptr;
    start_pos   = front;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op) inside
            dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
              strobe_next = 1'b1;
              if (count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
                result_next.status = dq_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                if (cmd.op == dq_pkg::ACT_PUSH_FRONT) begin
                  waddr      = dq_pkg::dec_idx(front);
                  front_next = dq_pkg::dec_idx(front);
                end else begin
                  waddr = dq_pkg::wrap_add(front, count);
                end
                count_next               = count + 1'b1;
                result_next.status       = dq_pkg::ST_PUSHED;
                result_next.result_value = dq_pkg::to_result(cmd.value);
              end
            end
            dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
              if (count == '0) begin
                strobe_next = 1'b1;
              end else begin
                if (cmd.op == dq_pkg::ACT_POP_FRONT) begin
                  raddr      = front;
                  front_next = dq_pkg::wrap_add(front, dq_pkg::CNT_W'(1));
                end else begin
                  raddr = dq_pkg::wrap_add(front, count - 1'b1);
                end
                count_next = count - 1'b1;
                state_next = S_POP;
              end
            end
            dq_pkg::ACT_LIST_FWD, dq_pkg::ACT_LIST_BWD: begin
              if (count == '0) begin
                strobe_next = 1'b1;
              end else begin
                dir_next   = (cmd.op == dq_pkg::ACT_LIST_BWD);
                start_pos  = dir_next ? dq_pkg::wrap_add(front, count - 1'b1) : front;
                raddr      = start_pos;
                ptr_next   = dq_pkg::step_idx(start_pos, dir_next);
                rem_next   = count;
                state_next = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        strobe_next              = 1'b1;
        result_next.status       = dq_pkg::ST_POPPED;
        result_next.result_value = dq_pkg::to_result(rdata);
        state_next               = S_IDLE;
      end
      S_LIST: begin
        raddr                    = ptr;
        ptr_next                 = dq_pkg::step_idx(ptr, dir);
        rem_next                 = rem - 1'b1;
        strobe_next              = 1'b1;
        result_next.status       = dq_pkg::ST_LISTED;
        result_next.result_value = dq_pkg::to_result(rdata);
        result_next.last         = (rem == dq_pkg::CNT_W'(1));
        if (rem == dq_pkg::CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold ring state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      front  <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      front  <= front_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    rem    <= rem_next;
    dir    <= dir_next;
    result <= result_next;
  end

  // Checks on the ring and the result sequencing
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_list_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> (rem != '0))
    else $error("listing with no entries left");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (strobe && result.status == dq_pkg::ST_POPPED && result.last))
    else $error("pop gave no popped result");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != dq_pkg::ST_LISTED) |-> result.last)
    else $error("single result without last mark");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd_take)
    else $error("command taken while back part busy");

endmodule
`default_nettype wire

@@ tb/dq_checker.sv @@
`timescale 1ns / 1ps
// Watches the command and result channels of the double-ended queue, keeps its own
// ring of entries and compares every strobed result with the oldest outstanding one.
module dq_checker
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  item,
  input  logic      strobe,
  input  out_item_t result,
  output int        err_count,
  output int        outstanding,
  output int        results_seen,
  output int        full_seen,
  output int        empty_seen
);

  // Shadow copy of the queue contents
  data_t     ring_store [DEPTH];
  int        head_pos;
  int        fill_level;
  out_item_t pending_results [$];

  initial begin
    err_count    = 0;
    outstanding  = 0;
    results_seen = 0;
    full_seen    = 0;
    empty_seen   = 0;
  end

  // Sign-extend a stored entry and cut it to the 32-bit result field
  function automatic logic signed [31:0] widen_entry(data_t d);
    logic signed [DATA_WIDTH-1:0] s;
    s = d;
    return 32'(s);
  endfunction

  function automatic out_item_t make_result(status_e st, logic signed [31:0] v, logic fin);
    out_item_t r;
    r.status       = st;
    r.result_value = v;
    r.last         = fin;
    return r;
  endfunction

  // Work out the results one accepted item causes and advance the shadow state
  task automatic predict_item(in_item_t it);
    logic signed [63:0] wide;
    data_t              stored;
    int                 pos;
    int                 i;
    wide   = 64'(it.item_value);
    stored = wide[DATA_WIDTH-1:0];
    case (it.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          pending_results.push_back(make_result(ST_FULL, '0, 1'b1));
        end else begin
          if (it.action == ACT_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            pos      = head_pos;
          end else begin
            pos = (head_pos + fill_level) % DEPTH;
          end
          ring_store[pos] = stored;
          fill_level++;
          pending_results.push_back(make_result(ST_PUSHED, widen_entry(stored), 1'b1));
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill_level == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          if (it.action == ACT_POP_FRONT) begin
            pos      = head_pos;
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            pos = (head_pos + fill_level - 1) % DEPTH;
          end
          fill_level--;
          pending_results.push_back(make_result(ST_POPPED, widen_entry(ring_store[pos]), 1'b1));
        end
      end
      ACT_LIST_FWD, ACT_LIST_BWD: begin
        if (fill_level == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (i = 0; i < fill_level; i++) begin
            if (it.action == ACT_LIST_FWD) begin
              pos = (head_pos + i) % DEPTH;
            end else begin
              pos = (head_pos + fill_level - 1 - i) % DEPTH;
            end
            pending_results.push_back(make_result(ST_LISTED, widen_entry(ring_store[pos]),
                                                  (i + 1 == fill_level)));
          end
        end
      end
      default: begin
        // unused codes: drop silently
      end
    endcase
  endtask

  // Compare one strobed result with the oldest expectation
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d value %0d last %0b",
             got.status, got.result_value, got.last);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      results_seen++;
      if (want.status == ST_FULL) full_seen++;
      if (want.status == ST_EMPTY) empty_seen++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        err_count++;
      end
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
        err_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        err_count++;
      end
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      head_pos   = 0;
      fill_level = 0;
      pending_results.delete();
    end else begin
      if (strobe === 1'b1) begin
        check_result(result);
      end
      if (start && busy === 1'b0) begin
        predict_item(item);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      strobe;
  out_item_t result;

  int err_count;
  int outstanding;
  int results_seen;
  int full_seen;
  int empty_seen;
  int cycle_count;
  int items_sent;
  bit idle_on;

  double_ended_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  dq_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .strobe       (strobe),
    .result       (result),
    .err_count    (err_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .empty_seen   (empty_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Favour the extremes, otherwise any 32-bit pattern
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, with an optional idle burst first, and hold until it is taken
  task automatic send_item(logic [2:0] act, logic signed [31:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{action: act, item_value: val};
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // Mixed traffic biased towards growth, with a few unused codes
  task automatic random_mix(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25)      send_item(ACT_PUSH_FRONT, pick_value());
      else if (r < 50) send_item(ACT_PUSH_BACK, pick_value());
      else if (r < 65) send_item(ACT_POP_FRONT, $urandom);
      else if (r < 80) send_item(ACT_POP_BACK, $urandom);
      else if (r < 88) send_item(ACT_LIST_FWD, $urandom);
      else if (r < 96) send_item(ACT_LIST_BWD, $urandom);
      else             send_item(3'($urandom_range(6, 7)), $urandom);
    end
  endtask

  // Push past capacity, list a full queue both ways, then push into it again
  task automatic fill_to_full();
    repeat (DEPTH + 4) begin
      send_item($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
    end
    send_item(ACT_LIST_FWD, $urandom);
    send_item(ACT_LIST_BWD, $urandom);
    send_item(ACT_PUSH_BACK, pick_value());
    send_item(ACT_PUSH_FRONT, pick_value());
  endtask

  // Pop past empty from either end, with a listing halfway
  task automatic drain_to_empty();
    int k;
    for (k = 0; k < DEPTH + 4; k++) begin
      send_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, $urandom);
      if (k == DEPTH / 2) send_item(ACT_LIST_BWD, $urandom);
    end
    send_item(ACT_LIST_FWD, $urandom);
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    items_sent = 0;
    idle_on    = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, extreme values, front wrap, unused codes, back to empty
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, -32'sd1);
    send_item(ACT_LIST_FWD, '0);
    send_item(ACT_LIST_BWD, '0);
    send_item(ACT_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_item(ACT_PUSH_BACK, '0);
    send_item(ACT_PUSH_FRONT, -32'sd1);
    send_item(ACT_PUSH_BACK, 32'sh5A5A_A5A5);
    send_item(ACT_LIST_FWD, '0);
    send_item(ACT_LIST_BWD, '0);
    send_item(3'd6, 32'sh1234_5678);
    send_item(3'd7, -32'sd1);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_LIST_FWD, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_LIST_BWD, '0);

    // Random: mixed traffic, full and empty sweeps, then a final stretch without idling
    random_mix(110);
    fill_to_full();
    drain_to_empty();
    idle_on = 1'b0;
    random_mix(70);
    start <= 1'b0;

    // Let the checker count the last item, then let its results arrive
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items; checked %0d results, %0d of them full and %0d empty reports.",
             items_sent, results_seen, full_seen, empty_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_front.sv
hdl/dq_back.sv
hdl/double_ended_queue.sv
tb/dq_checker.sv
tb/tb.sv
